@@ hw/rtl/qpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Queen placement counter package
// Shared widths, board constants and the control and status structures that
// pass between the top level and the search sequencer.
// ----------------------------------------------------------------------------
package qpc_pkg;

   // Default board edge; the top level parameter takes it as its default.
   localparam int QPC_BOARD_SIZE = 8;
   // Row stride inside the blocked-square mask, fixed whatever the board size.
   localparam int QPC_ROW_STRIDE = 8;
   localparam int QPC_BLOCKED_W  = 64;
   localparam int QPC_COUNT_W    = 7;
   // Largest count any legal board size can give (eight queens, empty board).
   localparam int QPC_COUNT_MAX  = 92;

   // Top level to sequencer.
   typedef struct packed {
      logic start;   // a board is being handed over this cycle
      logic ack;     // the finished count has been taken into the output register
   } qpc_ctrl_type;

   // Sequencer to top level.
   typedef struct packed {
      logic idle;    // ready for a new board
      logic done;    // count is final and waits to be taken
   } qpc_status_type;

endpackage

@@ hw/rtl/qpc_req_if.sv @@
// ----------------------------------------------------------------------------
// Board request channel
// Valid/ready channel that carries one blocked-square mask per transaction.
// ----------------------------------------------------------------------------
interface qpc_req_if;
   logic                                valid;
   logic                                ready;
   logic [qpc_pkg::QPC_BLOCKED_W-1:0]   blocked_cells;

   modport source (output valid, output blocked_cells, input ready);
   modport sink   (input valid, input blocked_cells, output ready);
endinterface

@@ hw/rtl/qpc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Count response channel
// Valid/ready channel that carries one placement count per transaction.
// ----------------------------------------------------------------------------
interface qpc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [qpc_pkg::QPC_COUNT_W-1:0]   placement_count;

   modport source (output valid, output placement_count, input ready);
   modport sink   (input valid, input placement_count, output ready);
endinterface

@@ hw/rtl/qpc_step.sv @@
// ----------------------------------------------------------------------------
// Queen placement step unit
// Takes the occupancy masks of one row, picks its lowest free column and
// forms the masks and free columns of the row below. Also counts free columns
// so that the last row is settled in one step.
// ----------------------------------------------------------------------------
module qpc_step #(
   parameter int BOARD_SIZE = qpc_pkg::QPC_BOARD_SIZE
) (
   input  logic [BOARD_SIZE-1:0]         cols,
   input  logic [BOARD_SIZE-1:0]         diag_up,
   input  logic [BOARD_SIZE-1:0]         diag_down,
   input  logic [BOARD_SIZE-1:0]         avail,
   input  logic [BOARD_SIZE-1:0]         next_blocked,
   output logic [BOARD_SIZE-1:0]         avail_rest,
   output logic [BOARD_SIZE-1:0]         child_cols,
   output logic [BOARD_SIZE-1:0]         child_up,
   output logic [BOARD_SIZE-1:0]         child_down,
   output logic [BOARD_SIZE-1:0]         child_avail,
   output logic [$clog2(BOARD_SIZE+1)-1:0] free_count
);
   import qpc_pkg::*;

   localparam int CW = $clog2(BOARD_SIZE+1);

   logic [BOARD_SIZE-1:0] pick;

   assign pick        = avail & (~avail + BOARD_SIZE'(1));
   assign avail_rest  = avail & ~pick;
   assign child_cols  = cols | pick;
   // The shift drops the column that leaves the board on either side.
   assign child_up    = (diag_up | pick) << 1;
   assign child_down  = (diag_down | pick) >> 1;
   assign child_avail = ~(child_cols | child_up | child_down | next_blocked);

   always_comb begin
      free_count = '0;
      for (int i = 0; i < BOARD_SIZE; i++) begin
         free_count = free_count + CW'(avail[i]);
      end
   end

endmodule

@@ hw/rtl/qpc_search.sv @@
// ----------------------------------------------------------------------------
// Queen placement search sequencer
// Walks the rows depth first with a per-row stack of occupancy masks and
// free columns, using the step unit once per cycle, and accumulates the count.
// ----------------------------------------------------------------------------
module qpc_search #(
   parameter int BOARD_SIZE = qpc_pkg::QPC_BOARD_SIZE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  qpc_pkg::qpc_ctrl_type               ctrl,
   input  logic [qpc_pkg::QPC_BLOCKED_W-1:0]   blocked_cells,
   output qpc_pkg::qpc_status_type             status,
   output logic [qpc_pkg::QPC_COUNT_W-1:0]     placement_count
);
   import qpc_pkg::*;

   localparam int RW = $clog2(BOARD_SIZE);
   localparam int CW = $clog2(BOARD_SIZE+1);
   localparam logic [RW-1:0] LAST_ROW = RW'(BOARD_SIZE-1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [RW-1:0]             row_ff, row_in;
   logic [QPC_COUNT_W-1:0]    count_ff, count_in;
   logic [QPC_BLOCKED_W-1:0]  blocked_ff;

   // Masks entering each row, and the columns of that row still to try.
   logic [BOARD_SIZE-1:0]     cols_ff  [BOARD_SIZE];
   logic [BOARD_SIZE-1:0]     up_ff    [BOARD_SIZE];
   logic [BOARD_SIZE-1:0]     down_ff  [BOARD_SIZE];
   logic [BOARD_SIZE-1:0]     avail_ff [BOARD_SIZE];

   logic [BOARD_SIZE-1:0]     next_blocked;
   logic [BOARD_SIZE-1:0]     avail_rest;
   logic [BOARD_SIZE-1:0]     child_cols;
   logic [BOARD_SIZE-1:0]     child_up;
   logic [BOARD_SIZE-1:0]     child_down;
   logic [BOARD_SIZE-1:0]     child_avail;
   logic [CW-1:0]             free_count;
   logic [RW-1:0]             next_row;
   logic                      at_last;
   logic                      cur_empty;
   logic                      take_pick;
   logic                      descend;

   assign next_row  = row_ff + RW'(1);
   assign at_last   = (row_ff == LAST_ROW);
   assign cur_empty = (avail_ff[row_ff] == '0);

   always_comb begin
      next_blocked = '0;
      for (int i = 0; i < BOARD_SIZE; i++) begin
         if (next_row == RW'(i)) begin
            next_blocked = blocked_ff[i*QPC_ROW_STRIDE +: BOARD_SIZE];
         end
      end
   end

   qpc_step #(
      .BOARD_SIZE(BOARD_SIZE)
   ) u_step (
      .cols         (cols_ff[row_ff]),
      .diag_up      (up_ff[row_ff]),
      .diag_down    (down_ff[row_ff]),
      .avail        (avail_ff[row_ff]),
      .next_blocked (next_blocked),
      .avail_rest   (avail_rest),
      .child_cols   (child_cols),
      .child_up     (child_up),
      .child_down   (child_down),
      .child_avail  (child_avail),
      .free_count   (free_count)
   );

   assign take_pick = (state_ff == ST_RUN) && !at_last && !cur_empty;
   // A child row with no free column is a dead end and is not entered.
   assign descend   = take_pick && (child_avail != '0);

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               state_in = ST_RUN;
               row_in   = '0;
               count_in = '0;
            end
         end
         ST_RUN: begin
            if (at_last) begin
               count_in = count_ff + QPC_COUNT_W'(free_count);
               row_in   = row_ff - RW'(1);
            end else if (cur_empty) begin
               if (row_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  row_in = row_ff - RW'(1);
               end
            end else if (descend) begin
               row_in = next_row;
            end
         end
         ST_DONE: begin
            if (ctrl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && ctrl.start) begin
         blocked_ff <= blocked_cells;
      end
      for (int i = 0; i < BOARD_SIZE; i++) begin
         if ((state_ff == ST_IDLE) && ctrl.start) begin
            if (i == 0) begin
               cols_ff[i]  <= '0;
               up_ff[i]    <= '0;
               down_ff[i]  <= '0;
               avail_ff[i] <= ~blocked_cells[BOARD_SIZE-1:0];
            end
         end else if (take_pick && (row_ff == RW'(i))) begin
            avail_ff[i] <= avail_rest;
         end else if (descend && (next_row == RW'(i))) begin
            cols_ff[i]  <= child_cols;
            up_ff[i]    <= child_up;
            down_ff[i]  <= child_down;
            avail_ff[i] <= child_avail;
         end
      end
   end

   assign status.idle      = (state_ff == ST_IDLE);
   assign status.done      = (state_ff == ST_DONE);
   assign placement_count  = count_ff;

endmodule

@@ hw/rtl/queens_placement_counter.sv @@
// ----------------------------------------------------------------------------
// Queen placement counter
// Counts the non-attacking one-queen-per-row placements on a board with
// blocked squares, by a depth-first search over the rows.
// ----------------------------------------------------------------------------
// Usage. A board arrives as one transaction on req_chan: bit row*8+col of
// blocked_cells set means no queen may stand on that square. Bits for rows or
// columns at or beyond BOARD_SIZE are ignored. Blocked squares do not stop
// attack lines. Exactly one transaction leaves on rsp_chan for each board,
// carrying placement_count.
// Search. Each step either places a queen in the lowest free column of a row
// above the last, backs out of a row whose columns are all tried, or settles
// the last row at once by counting its free columns. A pick whose child row
// has no free column is a dead end and is not entered. The shared step unit
// and its per-row stack set the running time, and a new board is taken only
// once the previous count has left the sequencer.
// Stalls. The count sits in an output register, so the next board is taken
// while the receiver stalls; a second finished count waits in the sequencer.
// Reset clears the sequencer and the output valid flag but not the held count;
// a board in the search and a count waiting to leave are both lost.
// ----------------------------------------------------------------------------
module queens_placement_counter #(
   parameter int BOARD_SIZE = qpc_pkg::QPC_BOARD_SIZE
) (
   input  logic          clock,
   input  logic          reset,
   qpc_req_if.sink       req_chan,
   qpc_rsp_if.source     rsp_chan
);
   import qpc_pkg::*;

   qpc_ctrl_type             ctrl;
   qpc_status_type           status;
   logic [QPC_COUNT_W-1:0]   search_count;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [QPC_COUNT_W-1:0]   rsp_count_ff;
   logic                     load;

   // The count moves on when the output register is empty or being emptied.
   assign load       = status.done && (!rsp_valid_ff || rsp_chan.ready);
   assign ctrl.start = req_chan.valid && status.idle;
   assign ctrl.ack   = load;

   assign req_chan.ready = status.idle;

   qpc_search #(
      .BOARD_SIZE(BOARD_SIZE)
   ) u_search (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .blocked_cells   (req_chan.blocked_cells),
      .status          (status),
      .placement_count (search_count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_count_ff <= search_count;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.placement_count = rsp_count_ff;

endmodule

@@ hw/rtl/qpc_checker.sv @@
// ----------------------------------------------------------------------------
// Queen placement counter checker
// Port-level properties of the counter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module qpc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [qpc_pkg::QPC_COUNT_W-1:0]   placement_count
);
   import qpc_pkg::*;

   // A stalled count holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(placement_count))
      else $error("count changed while stalled");

   // Once a board is taken the block is busy with it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a board was taken");

   // No count can exceed the eight-queens total.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> placement_count <= QPC_COUNT_W'(QPC_COUNT_MAX))
      else $error("count out of range");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind queens_placement_counter qpc_checker u_qpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .placement_count (rsp_chan.placement_count)
);
